@@ hdl/ilp_pkg.sv @@
// ----------------------------------------------------------------------------
// ilp_pkg
// shared types and constants of the integer literal parser
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int MAX_TOKEN_LEN_DEF = 255;

  localparam int CHAR_W   = 8;
  localparam int OUT_VAL_W = 32;
  localparam int POS_W    = 8;
  localparam int DIGIT_W  = 4;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_BIN = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_DEC       = 3'd2,
    ERR_OCT       = 3'd3,
    ERR_BIN       = 3'd4,
    ERR_HEX_DIGIT = 3'd5,
    ERR_HEX_EMPTY = 3'd6,
    ERR_START     = 3'd7
  } err_t;

  typedef struct packed {
    phase_t phase;
    logic   neg;
    base_t  base;
    err_t   err;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{phase: PH_START, neg: 1'b0, base: BASE_DEC, err: ERR_NONE};

  typedef struct packed {
    logic                 is_int;
    logic [OUT_VAL_W-1:0] value;
    err_t                 code;
    logic [POS_W-1:0]     pos;
  } res_t;

endpackage

@@ hdl/ilp_step.sv @@
// ----------------------------------------------------------------------------
// ilp_step
// next parse state and token result for one character
// ----------------------------------------------------------------------------
module ilp_step #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_TOKEN_LEN = ilp_pkg::MAX_TOKEN_LEN_DEF,
  parameter int IDX_W = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic [ilp_pkg::CHAR_W-1:0] char_i,
  input  logic                       last_i,
  input  ilp_pkg::ctl_t              ctl_i,
  input  logic [VALUE_WIDTH-1:0]     acc_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [IDX_W-1:0]           err_idx_i,
  output ilp_pkg::ctl_t              ctl_o,
  output logic [VALUE_WIDTH-1:0]     acc_o,
  output logic [IDX_W-1:0]           idx_o,
  output logic [IDX_W-1:0]           err_idx_o,
  output ilp_pkg::res_t              res_o
);

  localparam int EXT_W = VALUE_WIDTH + ilp_pkg::OUT_VAL_W;
  localparam int PEXT_W = IDX_W + ilp_pkg::POS_W;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CASE_BIT = 8'h20;

  function automatic ilp_pkg::err_t bad_digit(input ilp_pkg::base_t b);
    ilp_pkg::err_t e;
    unique case (b)
      ilp_pkg::BASE_DEC: e = ilp_pkg::ERR_DEC;
      ilp_pkg::BASE_OCT: e = ilp_pkg::ERR_OCT;
      ilp_pkg::BASE_BIN: e = ilp_pkg::ERR_BIN;
      default:           e = ilp_pkg::ERR_HEX_DIGIT;
    endcase
    return e;
  endfunction

  logic                          is_num;
  logic                          is_uhex;
  logic                          is_lhex;
  logic [7:0]                    dig_full;
  logic [ilp_pkg::DIGIT_W-1:0]   dig;
  logic                          dig_ok;
  logic [VALUE_WIDTH-1:0]        acc_mul;
  logic [VALUE_WIDTH-1:0]        acc_dig;
  logic [7:0]                    lc;
  ilp_pkg::ctl_t                 ctl_t1;
  logic [VALUE_WIDTH-1:0]        acc_t1;
  logic [IDX_W-1:0]              err_idx_t1;
  logic [VALUE_WIDTH-1:0]        val;
  logic signed [EXT_W-1:0]       val_ext;
  logic [PEXT_W-1:0]             pos_ext;

  // digit decode
  always_comb begin
    is_num  = (char_i >= CH_0) && (char_i <= CH_9);
    is_uhex = (char_i >= CH_UA) && (char_i <= CH_UF);
    is_lhex = (char_i >= CH_LA) && (char_i <= CH_LF);
    if (is_num) begin
      dig_full = char_i - CH_0;
    end else if (is_uhex) begin
      dig_full = char_i - 8'h37;
    end else begin
      dig_full = char_i - 8'h57;
    end
    dig = dig_full[ilp_pkg::DIGIT_W-1:0];
    case (ctl_i.base)
      ilp_pkg::BASE_DEC: begin
        dig_ok  = is_num;
        acc_mul = (acc_i << 3) + (acc_i << 1);
      end
      ilp_pkg::BASE_OCT: begin
        dig_ok  = is_num && (char_i <= CH_7);
        acc_mul = acc_i << 3;
      end
      ilp_pkg::BASE_BIN: begin
        dig_ok  = is_num && (char_i <= CH_1);
        acc_mul = acc_i << 1;
      end
      default: begin
        dig_ok  = is_num || is_uhex || is_lhex;
        acc_mul = acc_i << 4;
      end
    endcase
    acc_dig = acc_mul + VALUE_WIDTH'(dig);
    lc = char_i | CASE_BIT;
  end

  // character step
  always_comb begin
    ctl_t1     = ctl_i;
    acc_t1     = acc_i;
    err_idx_t1 = err_idx_i;
    unique case (ctl_i.phase) inside
      ilp_pkg::PH_START, ilp_pkg::PH_SIGN: begin
        if ((ctl_i.phase == ilp_pkg::PH_START) && ((char_i == CH_PLUS) || (char_i == CH_MINUS))) begin
          ctl_t1.neg   = (char_i == CH_MINUS);
          ctl_t1.phase = ilp_pkg::PH_SIGN;
        end else if (char_i == CH_0) begin
          ctl_t1.phase = ilp_pkg::PH_ZERO;
        end else if (is_num) begin
          ctl_t1.base  = ilp_pkg::BASE_DEC;
          acc_t1       = VALUE_WIDTH'(dig);
          ctl_t1.phase = ilp_pkg::PH_DIGITS;
        end else begin
          ctl_t1.err   = (ctl_i.phase == ilp_pkg::PH_START) ? ilp_pkg::ERR_START
                                                             : ilp_pkg::ERR_DEC;
          err_idx_t1   = idx_i;
          ctl_t1.phase = ilp_pkg::PH_ERROR;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (lc == CH_LX) begin
          ctl_t1.base  = ilp_pkg::BASE_HEX;
          ctl_t1.phase = ilp_pkg::PH_PREFIX;
        end else if (lc == CH_LB) begin
          ctl_t1.base  = ilp_pkg::BASE_BIN;
          ctl_t1.phase = ilp_pkg::PH_PREFIX;
        end else if (is_num && (char_i <= CH_7)) begin
          ctl_t1.base  = ilp_pkg::BASE_OCT;
          acc_t1       = VALUE_WIDTH'(dig);
          ctl_t1.phase = ilp_pkg::PH_DIGITS;
        end else begin
          ctl_t1.err   = ilp_pkg::ERR_OCT;
          err_idx_t1   = idx_i;
          ctl_t1.phase = ilp_pkg::PH_ERROR;
        end
      end
      ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: begin
        if (!dig_ok) begin
          ctl_t1.err   = bad_digit(ctl_i.base);
          err_idx_t1   = idx_i;
          ctl_t1.phase = ilp_pkg::PH_ERROR;
        end else begin
          acc_t1       = acc_dig;
          ctl_t1.phase = ilp_pkg::PH_DIGITS;
        end
      end
      default: ;
    endcase

    // end of token checks
    if (last_i && (ctl_t1.phase == ilp_pkg::PH_SIGN)) begin
      ctl_t1.err   = ilp_pkg::ERR_EMPTY;
      err_idx_t1   = idx_i;
      ctl_t1.phase = ilp_pkg::PH_ERROR;
    end else if (last_i && (ctl_t1.phase == ilp_pkg::PH_PREFIX)) begin
      ctl_t1.err   = (ctl_t1.base == ilp_pkg::BASE_HEX) ? ilp_pkg::ERR_HEX_EMPTY
                                                        : ilp_pkg::ERR_EMPTY;
      err_idx_t1   = idx_i;
      ctl_t1.phase = ilp_pkg::PH_ERROR;
    end
  end

  // result and next state
  always_comb begin
    val     = ctl_t1.neg ? (~acc_t1 + VALUE_WIDTH'(1)) : acc_t1;
    val_ext = EXT_W'($signed(val));
    pos_ext = PEXT_W'(err_idx_t1);
    if (ctl_t1.err == ilp_pkg::ERR_NONE) begin
      res_o.is_int = 1'b1;
      res_o.value  = val_ext[ilp_pkg::OUT_VAL_W-1:0];
      res_o.code   = ilp_pkg::ERR_NONE;
      res_o.pos    = '0;
    end else begin
      res_o.is_int = 1'b0;
      res_o.value  = '0;
      res_o.code   = ctl_t1.err;
      res_o.pos    = (pos_ext > PEXT_W'(255)) ? '1 : pos_ext[ilp_pkg::POS_W-1:0];
    end

    if (last_i) begin
      ctl_o     = ilp_pkg::CTL_RESET;
      acc_o     = '0;
      idx_o     = '0;
      err_idx_o = '0;
    end else begin
      ctl_o     = ctl_t1;
      acc_o     = acc_t1;
      idx_o     = (idx_i < IDX_W'(MAX_TOKEN_LEN)) ? idx_i + IDX_W'(1) : idx_i;
      err_idx_o = err_idx_t1;
    end
  end

endmodule

@@ hdl/integer_literal_parser_top.sv @@
// ----------------------------------------------------------------------------
// integer_literal_parser_top
// a request with tlast goes from the input register through the parse step
// into the result register; one character per cycle by the single parse
// step stage, taken while a finished result waits in the output register,
// until the next request with tlast reaches the parse step and waits there
// reset: synchronous rst_n clears the pipeline valids and the parse state
// ----------------------------------------------------------------------------
module integer_literal_parser_top #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_TOKEN_LEN = ilp_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] literal_value, [34:32] error_code,
                                  // [42:35] error_position, [47:43] zero
  output logic        out_tuser   // [0] is_integer
);

  localparam int IDX_W = $clog2(MAX_TOKEN_LEN + 1);

  logic                          s1_valid_r;
  logic [ilp_pkg::CHAR_W-1:0]    s1_char_r;
  logic                          s1_last_r;
  logic                          s1_adv;

  ilp_pkg::ctl_t                 ctl_r;
  ilp_pkg::ctl_t                 ctl_nxt;
  logic [VALUE_WIDTH-1:0]        acc_r;
  logic [VALUE_WIDTH-1:0]        acc_nxt;
  logic [IDX_W-1:0]              idx_r;
  logic [IDX_W-1:0]              idx_nxt;
  logic [IDX_W-1:0]              err_idx_r;
  logic [IDX_W-1:0]              err_idx_nxt;
  ilp_pkg::res_t                 res_nxt;

  logic                          out_valid_r;
  ilp_pkg::res_t                 res_r;

  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  ilp_step #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .IDX_W         (IDX_W)
  ) u_step (
    .char_i    (s1_char_r),
    .last_i    (s1_last_r),
    .ctl_i     (ctl_r),
    .acc_i     (acc_r),
    .idx_i     (idx_r),
    .err_idx_i (err_idx_r),
    .ctl_o     (ctl_nxt),
    .acc_o     (acc_nxt),
    .idx_o     (idx_nxt),
    .err_idx_o (err_idx_nxt),
    .res_o     (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= ilp_pkg::CTL_RESET;
      acc_r     <= '0;
      idx_r     <= '0;
      err_idx_r <= '0;
    end else if (s1_adv) begin
      ctl_r     <= ctl_nxt;
      acc_r     <= acc_nxt;
      idx_r     <= idx_nxt;
      err_idx_r <= err_idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.is_int;
  assign out_tdata  = {5'd0, res_r.pos, res_r.code, res_r.value};

endmodule
